// ----- src/pdot_pkg.sv -----
`default_nettype none

package pdot_pkg;

  localparam int PERIOD_BITS = 32;

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

endpackage

`default_nettype wire

// ----- src/pdot_in_if.sv -----
`default_nettype none

interface pdot_in_if #(
  parameter int TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [TIME_BITS-1:0] now_time;

  modport source (output valid, output cmd, output now_time, input ready);
  modport sink (input valid, input cmd, input now_time, output ready);
endinterface

`default_nettype wire

// ----- src/pdot_out_if.sv -----
`default_nettype none

interface pdot_out_if #(
  parameter int TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] missed_periods;
  logic [TIME_BITS-1:0] deadline_time;

  modport source (output valid, output missed_periods, output deadline_time, input ready);
  modport sink (input valid, input missed_periods, input deadline_time, output ready);
endinterface

`default_nettype wire

// ----- src/periodic_deadline_overrun_tracker_top.sv -----
// Periodic deadline overrun tracker.
// Input channel in_ch carries a command (advance or restart) and the current
// time; output channel out_ch returns exactly one word per input word: the
// number of missed periods and the deadline now held. The loop period is
// written through period_we / period_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. An input word is
// taken only while the sequencer is idle; one shared adder does the deadline add,
// the compare and the final sums, and the divider produces one quotient bit per cycle.
// Steps: restart or zero period goes straight to the done state and the output
// register; an advance runs the deadline add and the compare, and with an overrun
// also the bit-serial divide, the increment and the saturating sum.
// A new input word is not taken before the last one has left the sequencer.
// Reset clears the deadline and the period to zero and empties the output.
// If the receiver stalls, the finished word waits in the output register and
// a second finished word waits in the sequencer; no input is taken meanwhile.
`default_nettype none

module periodic_deadline_overrun_tracker_top
  import pdot_pkg::*;
#(
  parameter int TIME_BITS = 48
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   period_we,
  input  wire logic [PERIOD_BITS-1:0] period_wdata,
  pdot_in_if.sink                     in_ch,
  pdot_out_if.source                  out_ch
);

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CMP,
    ST_DIV,
    ST_INC,
    ST_SAT,
    ST_DONE
  } state_t;

  state_t                 state;
  logic [PERIOD_BITS-1:0] period;
  logic [TIME_BITS-1:0]   deadline;
  logic [TIME_BITS-1:0]   now_r;
  logic [TIME_BITS-1:0]   missed;
  logic                   out_valid;
  logic [TIME_BITS-1:0]   out_missed;
  logic [TIME_BITS-1:0]   out_deadline;

  // shared adder
  logic [TIME_BITS-1:0]   op_a;
  logic [TIME_BITS-1:0]   op_b;
  logic                   cin;
  logic [TIME_BITS:0]     sum;
  logic [TIME_BITS-1:0]   sat_sum;

  logic                   div_start;
  logic                   div_done;
  logic [TIME_BITS-1:0]   quot;
  logic                   in_take;

  always_comb begin
    unique case (state)
      ST_ADD: begin
        op_a = deadline;
        op_b = TIME_BITS'(period);
        cin  = 1'b0;
      end
      ST_CMP: begin
        op_a = now_r;
        op_b = ~deadline;
        cin  = 1'b1;
      end
      ST_INC: begin
        op_a = quot;
        op_b = '0;
        cin  = 1'b1;
      end
      ST_SAT: begin
        op_a = now_r;
        op_b = TIME_BITS'(period);
        cin  = 1'b0;
      end
      default: begin
        op_a = '0;
        op_b = '0;
        cin  = 1'b0;
      end
    endcase
  end

  assign sum     = {1'b0, op_a} + {1'b0, op_b} + {{TIME_BITS{1'b0}}, cin};
  assign sat_sum = (sum[TIME_BITS] | (&sum[TIME_BITS-1:0])) ? TIME_MAX : sum[TIME_BITS-1:0];

  // carry out in the compare step means now >= deadline: an overrun
  assign div_start = (state == ST_CMP) && sum[TIME_BITS];

  pdot_div #(
    .DIVIDEND_BITS(TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum[TIME_BITS-1:0]),
    .divisor  (period),
    .done     (div_done),
    .quotient (quot)
  );

  assign in_ch.ready = (state == ST_IDLE);
  assign in_take     = in_ch.valid && (state == ST_IDLE);

  assign out_ch.valid          = out_valid;
  assign out_ch.missed_periods = out_missed;
  assign out_ch.deadline_time  = out_deadline;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      period    <= '0;
      deadline  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (period_we) begin
        period <= period_wdata;
      end
      // in ST_DONE the output register is reloaded below instead
      if (out_valid && out_ch.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            now_r <= in_ch.now_time;
            if ((in_ch.cmd == CMD_RESTART) || (period == '0)) begin
              deadline <= in_ch.now_time;
              missed   <= '0;
              state    <= ST_DONE;
            end else begin
              state <= ST_ADD;
            end
          end
        end
        ST_ADD: begin
          deadline <= sat_sum;
          state    <= ST_CMP;
        end
        ST_CMP: begin
          if (sum[TIME_BITS]) begin
            state <= ST_DIV;
          end else begin
            missed <= '0;
            state  <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_INC;
          end
        end
        ST_INC: begin
          missed <= sum[TIME_BITS-1:0];
          state  <= ST_SAT;
        end
        ST_SAT: begin
          deadline <= sat_sum;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_missed   <= missed;
            out_deadline <= deadline;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/pdot_div.sv -----
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module pdot_div
  import pdot_pkg::*;
#(
  parameter int DIVIDEND_BITS = 48
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [DIVIDEND_BITS-1:0] dividend,
  input  wire logic [PERIOD_BITS-1:0]   divisor,
  output logic                          done,
  output logic [DIVIDEND_BITS-1:0]      quotient
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic                     busy;
  logic [CNT_BITS-1:0]      count;
  logic [DIVIDEND_BITS-1:0] dq;    // dividend shifts out the top, quotient in the bottom
  logic [PERIOD_BITS-1:0]   rem;

  logic [PERIOD_BITS+1:0]   trial;
  logic                     fits;

  assign trial = {1'b0, rem, dq[DIVIDEND_BITS-1]} - {2'b00, divisor};
  assign fits  = ~trial[PERIOD_BITS+1];
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      if (start) begin
        busy  <= 1'b1;
        done  <= 1'b0;
        count <= CNT_BITS'(DIVIDEND_BITS);
        dq    <= dividend;
        rem   <= '0;
      end else if (busy) begin
        // remainder stays below divisor, so 32 bits always hold it
        rem   <= fits ? trial[PERIOD_BITS-1:0] : {rem[PERIOD_BITS-2:0], dq[DIVIDEND_BITS-1]};
        dq    <= {dq[DIVIDEND_BITS-2:0], fits};
        count <= count - CNT_BITS'(1);
        done  <= (count == CNT_BITS'(1));
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
